// ===== hdl/umsc_pkg.sv =====
// Shared types and constants for the motor/servo command parser.
`default_nettype none

package umsc_pkg;

  // Field widths
  localparam int unsigned MagW   = 16;
  localparam int unsigned DutyW  = 10;
  localparam int unsigned ServoW = 15;
  localparam int unsigned MsW    = 11;

  // Saturation limits
  localparam logic [MagW-1:0] MAG_MAX = 16'hFFFF;
  localparam logic [MsW-1:0]  MS_MAX  = 11'h7FF;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd0;
  localparam logic [2:0] REG_SERVO_MIN   = 3'd1;
  localparam logic [2:0] REG_SERVO_MAX   = 3'd2;
  localparam logic [2:0] REG_SERVO_RESET = 3'd3;
  localparam logic [2:0] REG_TIMEOUT_MS  = 3'd4;

  // Register reset values
  localparam logic [DutyW-1:0]  SPEED_LIMIT_RST = 10'd999;
  localparam logic [ServoW-1:0] SERVO_MIN_RST   = 15'd1100;
  localparam logic [ServoW-1:0] SERVO_MAX_RST   = 15'd1900;
  localparam logic [ServoW-1:0] SERVO_RESET_RST = 15'd1500;
  localparam logic [DutyW-1:0]  TIMEOUT_MS_RST  = 10'd500;

  // What the parser hands to the actuator side
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TICK = 2'd1,
    KIND_CMD  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e           kind;
    logic            first_neg;
    logic [MagW-1:0] first_mag;
    logic            second_neg;
    logic [MagW-1:0] second_mag;
  } cmd_t;

  // Live configuration seen by the actuator side
  typedef struct packed {
    logic [DutyW-1:0]  speed_limit;
    logic [ServoW-1:0] servo_min;
    logic [ServoW-1:0] servo_max;
    logic [DutyW-1:0]  timeout_ms;
  } cfg_t;

  // One result word
  typedef struct packed {
    logic              drive_forward;
    logic              drive_reverse;
    logic [DutyW-1:0]  motor_duty;
    logic [ServoW-1:0] servo_pulse;
    logic              led_on;
    logic              command_accepted;
    logic              link_lost;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/umsc_fifo.sv =====
// Small register FIFO used between the parser, the actuator side and the output.
`default_nettype none

module umsc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/umsc_front.sv =====
// Line parser: classifies each item and assembles "speed,angle" lines.
`default_nettype none

module umsc_front
  import umsc_pkg::*;
#(
  parameter int unsigned LINE_MAX_CHARS = 60
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  input  wire logic       op_i,
  input  wire logic [7:0] rx_byte_i,
  output cmd_t            word_o
);

  localparam int unsigned CntW = $clog2(LINE_MAX_CHARS + 1);

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [7:0] {
    PH_START = 8'b0000_0001,
    PH_SIGN1 = 8'b0000_0010,
    PH_DIG1  = 8'b0000_0100,
    PH_WS2   = 8'b0000_1000,
    PH_SIGN2 = 8'b0001_0000,
    PH_DIG2  = 8'b0010_0000,
    PH_DONE  = 8'b0100_0000,
    PH_FAIL  = 8'b1000_0000
  } phase_e;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // Append one decimal digit, saturating the magnitude
  function automatic logic [MagW-1:0] add_digit(input logic [MagW-1:0] mag,
                                                input logic [7:0]      c);
    logic [MagW+3:0] v;
    v = (MagW+4)'(mag) * (MagW+4)'(10) + (MagW+4)'(c[3:0]);
    return (v > (MagW+4)'(MAG_MAX)) ? MAG_MAX : v[MagW-1:0];
  endfunction

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            f_neg_q, f_neg_d, s_neg_q, s_neg_d;
  logic [MagW-1:0] f_mag_q, f_mag_d, s_mag_q, s_mag_d;
  logic            line_ok;
  kind_e           kind;

  assign line_ok = (phase_q == PH_DIG2) || (phase_q == PH_DONE);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    f_neg_d = f_neg_q;
    f_mag_d = f_mag_q;
    s_neg_d = s_neg_q;
    s_mag_d = s_mag_q;
    kind    = KIND_NONE;
    if (valid_i) begin
      if (op_i) begin
        kind = KIND_TICK;
      end else if (rx_byte_i == CHAR_CR) begin
        kind = KIND_NONE;
      end else if (rx_byte_i == CHAR_LF) begin
        // End of line: hand over a good line, then start over
        if (line_ok) begin
          kind = KIND_CMD;
        end
        phase_d = PH_START;
        cnt_d   = '0;
        f_neg_d = 1'b0;
        f_mag_d = '0;
        s_neg_d = 1'b0;
        s_mag_d = '0;
      end else if (cnt_q < CntW'(LINE_MAX_CHARS)) begin
        cnt_d = cnt_q + 1'b1;
        if (rx_byte_i == CHAR_NUL) begin
          // Terminate the string early
          phase_d = line_ok ? PH_DONE : PH_FAIL;
        end else begin
          case (phase_q)
            PH_START, PH_WS2: begin
              if (is_blank(rx_byte_i)) begin
                phase_d = phase_q;
              end else if (rx_byte_i == CHAR_MINUS || rx_byte_i == CHAR_PLUS) begin
                if (phase_q == PH_START) begin
                  f_neg_d = (rx_byte_i == CHAR_MINUS);
                  phase_d = PH_SIGN1;
                end else begin
                  s_neg_d = (rx_byte_i == CHAR_MINUS);
                  phase_d = PH_SIGN2;
                end
              end else if (is_digit(rx_byte_i)) begin
                if (phase_q == PH_START) begin
                  f_mag_d = add_digit('0, rx_byte_i);
                  phase_d = PH_DIG1;
                end else begin
                  s_mag_d = add_digit('0, rx_byte_i);
                  phase_d = PH_DIG2;
                end
              end else begin
                phase_d = PH_FAIL;
              end
            end
            PH_SIGN1: begin
              if (is_digit(rx_byte_i)) begin
                f_mag_d = add_digit('0, rx_byte_i);
                phase_d = PH_DIG1;
              end else begin
                phase_d = PH_FAIL;
              end
            end
            PH_DIG1: begin
              if (is_digit(rx_byte_i)) begin
                f_mag_d = add_digit(f_mag_q, rx_byte_i);
              end else if (rx_byte_i == CHAR_COMMA) begin
                phase_d = PH_WS2;
              end else begin
                phase_d = PH_FAIL;
              end
            end
            PH_SIGN2: begin
              if (is_digit(rx_byte_i)) begin
                s_mag_d = add_digit('0, rx_byte_i);
                phase_d = PH_DIG2;
              end else begin
                phase_d = PH_FAIL;
              end
            end
            PH_DIG2: begin
              if (is_digit(rx_byte_i)) begin
                s_mag_d = add_digit(s_mag_q, rx_byte_i);
              end else begin
                phase_d = PH_DONE;
              end
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
        end
      end else begin
        // Line too long: drop the byte and restart
        phase_d = PH_START;
        cnt_d   = '0;
        f_neg_d = 1'b0;
        f_mag_d = '0;
        s_neg_d = 1'b0;
        s_mag_d = '0;
      end
    end
  end

  // Word toward the actuator side carries the line as it stood before this item
  always_comb begin
    word_o.kind       = kind;
    word_o.first_neg  = f_neg_q;
    word_o.first_mag  = f_mag_q;
    word_o.second_neg = s_neg_q;
    word_o.second_mag = s_mag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      cnt_q   <= '0;
      f_neg_q <= 1'b0;
      f_mag_q <= '0;
      s_neg_q <= 1'b0;
      s_mag_q <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      f_neg_q <= f_neg_d;
      f_mag_q <= f_mag_d;
      s_neg_q <= s_neg_d;
      s_mag_q <= s_mag_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/umsc_back.sv =====
// Actuator side: applies commands and ticks to the motor, servo and LED state.
`default_nettype none

module umsc_back
  import umsc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic fire_i,
  input  wire cmd_t word_i,
  input  wire cfg_t cfg_i,
  output result_t   result_o
);

  logic              fwd_q, fwd_d, rev_q, rev_d, led_q, led_d;
  logic [DutyW-1:0]  duty_q, duty_d;
  logic [ServoW-1:0] servo_q, servo_d;
  logic [MsW-1:0]    ms_q, ms_d;
  logic [DutyW-1:0]  mag_lim;
  logic              below_min;
  logic [MagW-1:0]   ang_lo;
  logic              lost;
  logic              is_cmd;

  assign is_cmd = (word_i.kind == KIND_CMD);

  // Clamp the speed magnitude to the limit
  assign mag_lim = (word_i.first_mag > MagW'(cfg_i.speed_limit)) ?
                   cfg_i.speed_limit : word_i.first_mag[DutyW-1:0];

  // Lower servo clamp first; any negative angle sits below the range
  assign below_min = (word_i.second_neg && (word_i.second_mag != '0)) ||
                     (word_i.second_mag < MagW'(cfg_i.servo_min));
  assign ang_lo    = below_min ? MagW'(cfg_i.servo_min) : word_i.second_mag;

  always_comb begin
    fwd_d   = fwd_q;
    rev_d   = rev_q;
    duty_d  = duty_q;
    servo_d = servo_q;
    led_d   = led_q;
    ms_d    = ms_q;
    case (word_i.kind)
      KIND_TICK: begin
        if (ms_q < MS_MAX) begin
          ms_d = ms_q + 1'b1;
        end
      end
      KIND_CMD: begin
        ms_d   = '0;
        led_d  = !led_q;
        fwd_d  = (mag_lim != '0) && !word_i.first_neg;
        rev_d  = (mag_lim != '0) && word_i.first_neg;
        duty_d = mag_lim;
        servo_d = (ang_lo > MagW'(cfg_i.servo_max)) ?
                  cfg_i.servo_max : ang_lo[ServoW-1:0];
      end
      default: begin
        ms_d = ms_q;
      end
    endcase
    // Failsafe: stop the motor and drop the LED after the timeout
    lost = (ms_d > MsW'(cfg_i.timeout_ms));
    if (lost) begin
      duty_d = '0;
      led_d  = 1'b0;
    end
  end

  always_comb begin
    result_o.drive_forward    = fwd_d;
    result_o.drive_reverse    = rev_d;
    result_o.motor_duty       = duty_d;
    result_o.servo_pulse      = servo_d;
    result_o.led_on           = led_d;
    result_o.command_accepted = is_cmd;
    result_o.link_lost        = lost;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q   <= 1'b0;
      rev_q   <= 1'b0;
      duty_q  <= '0;
      servo_q <= SERVO_RESET_RST;
      led_q   <= 1'b0;
      ms_q    <= '0;
    end else if (fire_i) begin
      fwd_q   <= fwd_d;
      rev_q   <= rev_d;
      duty_q  <= duty_d;
      servo_q <= servo_d;
      led_q   <= led_d;
      ms_q    <= ms_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/uart_motor_servo_command_parser_core.sv =====
// Top level of the motor/servo command parser: config registers, parser, actuator, queues.
`default_nettype none

// One word goes in per clock and one result word comes out per input word, at a
// sustained rate of one word per cycle while results are popped and the queues
// do not fill. The parser classifies a word and updates the line state in the cycle
// it is taken, a two-entry queue hands it to the actuator side, which updates the
// motor, servo, LED and link timer and writes the result into a two-entry output
// queue. The parser accepts new words while earlier ones still wait in the queues.
// Bytes form lines "speed,angle" ended by newline; ticks count milliseconds toward
// the link timeout. Registers sit at byte addresses 0,4,8,12,16: speed limit, servo
// minimum, servo maximum, servo reset pulse (read back only; the servo resets to
// SERVO_RESET_RST), timeout in ms. Write configuration only while the block is idle.
module uart_motor_servo_command_parser_core
  import umsc_pkg::*;
#(
  parameter int unsigned LINE_MAX_CHARS = 60
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input queue side
  input  wire logic        push,
  output logic             full,
  input  wire logic        op_i,
  input  wire logic [7:0]  rx_byte_i,
  // Result queue side
  output logic             empty,
  input  wire logic        pop,
  output logic             drive_forward_o,
  output logic             drive_reverse_o,
  output logic [9:0]       motor_duty_o,
  output logic [14:0]      servo_pulse_o,
  output logic             led_on_o,
  output logic             command_accepted_o,
  output logic             link_lost_o
);

  logic [DutyW-1:0]  speed_limit_q, timeout_ms_q;
  logic [ServoW-1:0] servo_min_q, servo_max_q, servo_reset_q;
  logic [2:0]        reg_idx;
  logic              cfg_wr;
  cfg_t              cfg;

  logic    in_fire, cmd_full, cmd_empty, out_full, out_empty, back_fire;
  cmd_t    front_word, back_word;
  result_t back_result, out_result;

  // Register access
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_limit_q <= SPEED_LIMIT_RST;
      servo_min_q   <= SERVO_MIN_RST;
      servo_max_q   <= SERVO_MAX_RST;
      servo_reset_q <= SERVO_RESET_RST;
      timeout_ms_q  <= TIMEOUT_MS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SPEED_LIMIT: speed_limit_q <= pwdata[DutyW-1:0];
        REG_SERVO_MIN:   servo_min_q   <= pwdata[ServoW-1:0];
        REG_SERVO_MAX:   servo_max_q   <= pwdata[ServoW-1:0];
        REG_SERVO_RESET: servo_reset_q <= pwdata[ServoW-1:0];
        REG_TIMEOUT_MS:  timeout_ms_q  <= pwdata[DutyW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SPEED_LIMIT: prdata = 32'(speed_limit_q);
      REG_SERVO_MIN:   prdata = 32'(servo_min_q);
      REG_SERVO_MAX:   prdata = 32'(servo_max_q);
      REG_SERVO_RESET: prdata = 32'(servo_reset_q);
      REG_TIMEOUT_MS:  prdata = 32'(timeout_ms_q);
      default:         prdata = '0;
    endcase
  end

  always_comb begin
    cfg.speed_limit = speed_limit_q;
    cfg.servo_min   = servo_min_q;
    cfg.servo_max   = servo_max_q;
    cfg.timeout_ms  = timeout_ms_q;
  end

  // Front: accept and classify
  assign full    = cmd_full;
  assign in_fire = push && !cmd_full;

  umsc_front #(
    .LINE_MAX_CHARS(LINE_MAX_CHARS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_fire),
    .op_i     (op_i),
    .rx_byte_i(rx_byte_i),
    .word_o   (front_word)
  );

  umsc_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_fire),
    .data_i (front_word),
    .pop_i  (back_fire),
    .data_o (back_word),
    .full_o (cmd_full),
    .empty_o(cmd_empty)
  );

  // Back: apply when a word waits and the output has room
  assign back_fire = !cmd_empty && !out_full;

  umsc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (back_fire),
    .word_i  (back_word),
    .cfg_i   (cfg),
    .result_o(back_result)
  );

  umsc_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(2)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (back_fire),
    .data_i (back_result),
    .pop_i  (pop),
    .data_o (out_result),
    .full_o (out_full),
    .empty_o(out_empty)
  );

  // Result ports
  assign empty              = out_empty;
  assign drive_forward_o    = out_result.drive_forward;
  assign drive_reverse_o    = out_result.drive_reverse;
  assign motor_duty_o       = out_result.motor_duty;
  assign servo_pulse_o      = out_result.servo_pulse;
  assign led_on_o           = out_result.led_on;
  assign command_accepted_o = out_result.command_accepted;
  assign link_lost_o        = out_result.link_lost;

endmodule

`default_nettype wire

// ===== hdl/umsc_checker.sv =====
// Port-level checks for the command parser, bound to the top level.
`default_nettype none

module umsc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        drive_forward_o,
  input wire logic        drive_reverse_o,
  input wire logic [9:0]  motor_duty_o,
  input wire logic [14:0] servo_pulse_o,
  input wire logic        led_on_o,
  input wire logic        command_accepted_o,
  input wire logic        link_lost_o
);

  // Never drive both directions at once
  a_dir_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> !(drive_forward_o && drive_reverse_o))
    else $error("both direction pins high");

  // Failsafe forces duty and LED low
  a_failsafe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && link_lost_o) |-> (motor_duty_o == 10'd0 && !led_on_o))
    else $error("link lost but motor or LED still active");

  // A fresh command clears the link timer
  a_cmd_not_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && command_accepted_o) |-> !link_lost_o)
    else $error("accepted command reported as link lost");

  // Stopped motor has zero duty
  a_stop_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !drive_forward_o && !drive_reverse_o) |-> (motor_duty_o == 10'd0))
    else $error("nonzero duty with no direction");

  // A waiting result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(motor_duty_o) && $stable(servo_pulse_o)))
    else $error("waiting result changed");

endmodule

bind uart_motor_servo_command_parser_core umsc_checker u_checker (.*);

`default_nettype wire

// ===== tb/tb_uart_motor_servo_command_parser_core.sv =====
// Testbench for the motor/servo command parser: directed lines, random traffic, scoreboard.
module tb_uart_motor_servo_command_parser_core;
  timeunit 1ns;
  timeprecision 1ps;
  import umsc_pkg::*;

  localparam int LINE_MAX_CHARS = 60;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_TICKS     = 40;

  // Character codes the parser cares about
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_X     = 8'h78;

  typedef enum logic [2:0] {
    LN_START, LN_SIGN1, LN_DIG1, LN_WS2, LN_SIGN2, LN_DIG2, LN_DONE, LN_FAIL
  } line_phase_e;

  typedef struct packed {
    logic       op;
    logic [7:0] ch;
    logic       typed;
    result_t    want;
  } row_t;

  // Outputs that can be read straight off the line
  localparam result_t RES_IDLE = '{drive_forward: 1'b0, drive_reverse: 1'b0, motor_duty: 10'd0,
                                   servo_pulse: SERVO_RESET_RST, led_on: 1'b0,
                                   command_accepted: 1'b0, link_lost: 1'b0};
  localparam result_t RES_FULL_REV = '{drive_forward: 1'b0, drive_reverse: 1'b1,
                                       motor_duty: SPEED_LIMIT_RST, servo_pulse: SERVO_MAX_RST,
                                       led_on: 1'b1, command_accepted: 1'b1, link_lost: 1'b0};
  localparam result_t RES_STOP = '{drive_forward: 1'b0, drive_reverse: 1'b0, motor_duty: 10'd0,
                                   servo_pulse: SERVO_MIN_RST, led_on: 1'b0,
                                   command_accepted: 1'b1, link_lost: 1'b0};

  // Directed lines: garbage, then " \t-70000,\v+2500\rx\n", then "0,5<NUL>\n"
  localparam row_t DIRECTED_ROWS [26] = '{
    '{1'b1, CH_NUL, 1'b1, RES_IDLE},
    '{1'b0, 8'hFF, 1'b1, RES_IDLE},
    '{1'b0, CH_LF, 1'b1, RES_IDLE},
    '{1'b0, CH_SP, 1'b0, '0},
    '{1'b0, CH_TAB, 1'b0, '0},
    '{1'b0, CH_MINUS, 1'b0, '0},
    '{1'b0, CH_ZERO + 8'd7, 1'b0, '0},
    '{1'b0, CH_ZERO, 1'b0, '0},
    '{1'b0, CH_ZERO, 1'b0, '0},
    '{1'b0, CH_ZERO, 1'b0, '0},
    '{1'b0, CH_ZERO, 1'b0, '0},
    '{1'b0, CH_COMMA, 1'b0, '0},
    '{1'b0, CH_VT, 1'b0, '0},
    '{1'b0, CH_PLUS, 1'b0, '0},
    '{1'b0, CH_ZERO + 8'd2, 1'b0, '0},
    '{1'b0, CH_ZERO + 8'd5, 1'b0, '0},
    '{1'b0, CH_ZERO, 1'b0, '0},
    '{1'b0, CH_ZERO, 1'b0, '0},
    '{1'b0, CH_CR, 1'b0, '0},
    '{1'b0, CH_X, 1'b0, '0},
    '{1'b0, CH_LF, 1'b1, RES_FULL_REV},
    '{1'b0, CH_ZERO, 1'b0, '0},
    '{1'b0, CH_COMMA, 1'b0, '0},
    '{1'b0, CH_ZERO + 8'd5, 1'b0, '0},
    '{1'b0, CH_NUL, 1'b0, '0},
    '{1'b0, CH_LF, 1'b1, RES_STOP}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic        op_i = 1'b0;
  logic [7:0]  rx_byte_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        drive_forward_o;
  logic        drive_reverse_o;
  logic [9:0]  motor_duty_o;
  logic [14:0] servo_pulse_o;
  logic        led_on_o;
  logic        command_accepted_o;
  logic        link_lost_o;

  uart_motor_servo_command_parser_core #(
    .LINE_MAX_CHARS(LINE_MAX_CHARS)
  ) dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .op_i, .rx_byte_i,
    .empty, .pop,
    .drive_forward_o, .drive_reverse_o, .motor_duty_o, .servo_pulse_o,
    .led_on_o, .command_accepted_o, .link_lost_o
  );

  // Parser and actuator shadow state
  line_phase_e ln_phase;
  int          ln_count, f_mag, s_mag;
  logic        f_neg, s_neg;
  logic        fwd_pin, rev_pin, led_lvl;
  int          duty_val, servo_val, ms_idle;
  int          lim_cfg, smin_cfg, smax_cfg, tmo_cfg;

  result_t     pending_outputs[$];
  result_t     want_word;
  logic [7:0]  line_buf[$];
  int          error_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  int          cycle_count = 0;
  logic        hold_request = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SP || c == CH_TAB || c == CH_VT || c == CH_FF;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Append one decimal digit, saturating the magnitude
  function automatic int add_digit(input int mag, input logic [7:0] c);
    int v;
    v = mag * 10 + int'(c - CH_ZERO);
    return (v > int'(MAG_MAX)) ? int'(MAG_MAX) : v;
  endfunction

  function automatic void restart_line();
    ln_phase = LN_START;
    ln_count = 0;
    f_neg = 1'b0;
    f_mag = 0;
    s_neg = 1'b0;
    s_mag = 0;
  endfunction

  function automatic void reset_shadow();
    lim_cfg  = int'(SPEED_LIMIT_RST);
    smin_cfg = int'(SERVO_MIN_RST);
    smax_cfg = int'(SERVO_MAX_RST);
    tmo_cfg  = int'(TIMEOUT_MS_RST);
    restart_line();
    fwd_pin = 1'b0;
    rev_pin = 1'b0;
    duty_val = 0;
    servo_val = int'(SERVO_RESET_RST);
    led_lvl = 1'b0;
    ms_idle = 0;
  endfunction

  // Advance the line parser by one counted character
  function automatic void take_char(input logic [7:0] c);
    if (c == CH_NUL) begin
      ln_phase = (ln_phase == LN_DIG2 || ln_phase == LN_DONE) ? LN_DONE : LN_FAIL;
      return;
    end
    case (ln_phase)
      LN_START, LN_WS2: begin
        if (!is_blank(c)) begin
          if (c == CH_MINUS || c == CH_PLUS) begin
            if (ln_phase == LN_START) begin
              f_neg = (c == CH_MINUS);
              ln_phase = LN_SIGN1;
            end else begin
              s_neg = (c == CH_MINUS);
              ln_phase = LN_SIGN2;
            end
          end else if (is_digit(c)) begin
            if (ln_phase == LN_START) begin
              f_mag = add_digit(0, c);
              ln_phase = LN_DIG1;
            end else begin
              s_mag = add_digit(0, c);
              ln_phase = LN_DIG2;
            end
          end else begin
            ln_phase = LN_FAIL;
          end
        end
      end
      LN_SIGN1: begin
        if (is_digit(c)) begin
          f_mag = add_digit(0, c);
          ln_phase = LN_DIG1;
        end else begin
          ln_phase = LN_FAIL;
        end
      end
      LN_DIG1: begin
        if (is_digit(c)) f_mag = add_digit(f_mag, c);
        else if (c == CH_COMMA) ln_phase = LN_WS2;
        else ln_phase = LN_FAIL;
      end
      LN_SIGN2: begin
        if (is_digit(c)) begin
          s_mag = add_digit(0, c);
          ln_phase = LN_DIG2;
        end else begin
          ln_phase = LN_FAIL;
        end
      end
      LN_DIG2: begin
        if (is_digit(c)) s_mag = add_digit(s_mag, c);
        else ln_phase = LN_DONE;
      end
      default: ;
    endcase
  endfunction

  // Drive motor and servo from a completed line
  function automatic void apply_line();
    int speed, angle;
    speed = f_neg ? -f_mag : f_mag;
    angle = s_neg ? -s_mag : s_mag;
    ms_idle = 0;
    led_lvl = ~led_lvl;
    if (speed > lim_cfg) speed = lim_cfg;
    if (speed < -lim_cfg) speed = -lim_cfg;
    fwd_pin = speed > 0;
    rev_pin = speed < 0;
    duty_val = (speed < 0) ? -speed : speed;
    // lower clamp first so the upper bound wins on an inverted range
    if (angle < smin_cfg) angle = smin_cfg;
    if (angle > smax_cfg) angle = smax_cfg;
    servo_val = angle;
  endfunction

  // Work out the output word that one accepted input word produces
  function automatic result_t parse_and_drive(input logic op, input logic [7:0] c);
    result_t r;
    logic    hit;
    logic    lost;
    hit = 1'b0;
    if (op) begin
      if (ms_idle < int'(MS_MAX)) ms_idle++;
    end else if (c == CH_CR) begin
      // drop carriage return without touching the line
    end else if (c == CH_LF) begin
      if (ln_phase == LN_DIG2 || ln_phase == LN_DONE) begin
        apply_line();
        hit = 1'b1;
      end
      restart_line();
    end else if (ln_count < LINE_MAX_CHARS) begin
      ln_count++;
      take_char(c);
    end else begin
      restart_line();
    end
    lost = ms_idle > tmo_cfg;
    if (lost) begin
      duty_val = 0;
      led_lvl = 1'b0;
    end
    r.drive_forward = fwd_pin;
    r.drive_reverse = rev_pin;
    r.motor_duty = duty_val[9:0];
    r.servo_pulse = servo_val[14:0];
    r.led_on = led_lvl;
    r.command_accepted = hit;
    r.link_lost = lost;
    return r;
  endfunction

  // Offer one word in bursts with random gaps; predict it once taken
  task automatic send_word(input logic op, input logic [7:0] c, input logic typed,
                           input result_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    push <= 1'b1;
    op_i <= op;
    rx_byte_i <= c;
    do @(posedge clk_i); while (full);
    want_word = parse_and_drive(op, c);
    pending_outputs.push_back(typed ? want : want_word);
    if (op || c != CH_CR) items_sent++;
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_word(1'b0, line_buf[i], 1'b0, '0);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(1'b1, 8'($urandom_range(255)), 1'b0, '0);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(3))
      0: return CH_SP;
      1: return CH_TAB;
      2: return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  function automatic void add_blanks();
    if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) line_buf.push_back(pick_blank());
  endfunction

  // Append an optionally signed decimal number of varied size
  function automatic void add_number();
    int    v;
    string s;
    case ($urandom_range(5))
      0: v = 0;
      1: v = $urandom_range(9);
      2: v = $urandom_range(1100);
      3: v = $urandom_range(25000);
      4: v = $urandom_range(99999);
      default: v = $urandom_range(999999, 60000);
    endcase
    case ($urandom_range(3))
      0: line_buf.push_back(CH_MINUS);
      1: line_buf.push_back(CH_PLUS);
      default: ;
    endcase
    if ($urandom_range(7) == 0) line_buf.push_back(CH_ZERO);
    s = $sformatf("%0d", v);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // Build "speed,angle" with optional padding, tail and line-end variants
  function automatic void compose_line(input logic long_pad);
    logic junk;
    line_buf.delete();
    if (long_pad) begin
      junk = ($urandom_range(9) < 3);
      repeat ($urandom_range(70, 50)) begin
        line_buf.push_back(junk ? 8'($urandom_range(126, 33)) : pick_blank());
      end
    end
    add_blanks();
    add_number();
    line_buf.push_back(CH_COMMA);
    add_blanks();
    add_number();
    case ($urandom_range(7))
      0: begin
        line_buf.push_back(CH_NUL);
        repeat ($urandom_range(3)) line_buf.push_back(8'($urandom_range(126, 32)));
      end
      1: repeat ($urandom_range(4, 1)) line_buf.push_back(8'($urandom_range(126, 33)));
      2: line_buf.push_back(pick_blank());
      default: ;
    endcase
    if ($urandom_range(3) == 0) line_buf.push_back(CH_CR);
    line_buf.push_back(CH_LF);
  endfunction

  // Break one spot of an otherwise well-formed line
  function automatic void damage_line();
    int i;
    i = $urandom_range(line_buf.size() - 2);
    case ($urandom_range(2))
      0: line_buf[i] = 8'($urandom_range(255));
      1: line_buf.delete(i);
      default: line_buf.insert(i, 8'($urandom_range(255)));
    endcase
  endfunction

  task automatic emit_random_sequence();
    int r, n;
    r = $urandom_range(99);
    if (r < 55) begin
      compose_line(1'b0);
      send_line();
    end else if (r < 65) begin
      compose_line(1'b0);
      damage_line();
      send_line();
    end else if (r < 72) begin
      compose_line(1'b1);
      send_line();
    end else if (r < 80) begin
      repeat ($urandom_range(6, 1)) send_word(1'b0, 8'($urandom_range(255)), 1'b0, '0);
    end else begin
      n = (tmo_cfg + 4 > 64) ? 64 : tmo_cfg + 4;
      send_ticks(($urandom_range(7) == 0) ? $urandom_range(n, 1) : $urandom_range(8, 1));
    end
  endtask

  task automatic run_random(input int n);
    int target;
    target = items_sent + n;
    while (items_sent < target) emit_random_sequence();
  endtask

  // Hold input until every predicted word has come back
  task automatic drain();
    push <= 1'b0;
    burst_left = 0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_cycle(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
                           output logic [31:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_register(input logic [2:0] idx, input logic [31:0] want);
    logic [31:0] rd;
    apb_cycle(1'b0, idx, '0, rd);
    check_field($sformatf("register %0d readback", idx), rd, want);
  endtask

  // Write a register, mirror it in the shadow config, read it back
  task automatic set_register(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] rd;
    apb_cycle(1'b1, idx, val, rd);
    case (idx)
      REG_SPEED_LIMIT: lim_cfg = int'(val[9:0]);
      REG_SERVO_MIN:   smin_cfg = int'(val[14:0]);
      REG_SERVO_MAX:   smax_cfg = int'(val[14:0]);
      REG_TIMEOUT_MS:  tmo_cfg = int'(val[9:0]);
      default: ;  // servo reset pulse register is only read back
    endcase
    check_register(idx, val);
  endtask

  // Compare each output word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_outputs.size() == 0) begin
        report_error("output word with nothing expected");
      end else begin
        want_word = pending_outputs.pop_front();
        check_field("drive_forward", drive_forward_o, want_word.drive_forward);
        check_field("drive_reverse", drive_reverse_o, want_word.drive_reverse);
        check_field("motor_duty", motor_duty_o, want_word.motor_duty);
        check_field("servo_pulse", servo_pulse_o, want_word.servo_pulse);
        check_field("led_on", led_on_o, want_word.led_on);
        check_field("command_accepted", command_accepted_o, want_word.command_accepted);
        check_field("link_lost", link_lost_o, want_word.link_lost);
      end
    end
  end

  // Receiver: stall on a changing duty pattern, or hold off on request
  initial begin : receiver
    int stall_pct, mode_left, hold_left;
    stall_pct = 0;
    mode_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        pop <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(posedge clk_i);
          hold_left--;
        end
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          case ($urandom_range(4))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            3: stall_pct = 60;
            default: stall_pct = 90;
          endcase
          mode_left = $urandom_range(80, 10);
        end
        mode_left--;
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [14:0] lo, hi;
    reset_shadow();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers come out of reset at their documented values
    check_register(REG_SPEED_LIMIT, 32'(SPEED_LIMIT_RST));
    check_register(REG_SERVO_MIN, 32'(SERVO_MIN_RST));
    check_register(REG_SERVO_MAX, 32'(SERVO_MAX_RST));
    check_register(REG_SERVO_RESET, 32'(SERVO_RESET_RST));
    check_register(REG_TIMEOUT_MS, 32'(TIMEOUT_MS_RST));

    foreach (DIRECTED_ROWS[i]) begin
      send_word(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].want);
    end
    run_random(150);
    drain();

    // No drive allowed, wide servo window, instant timeout
    set_register(REG_SPEED_LIMIT, 32'd0);
    set_register(REG_SERVO_MIN, 32'd0);
    set_register(REG_SERVO_MAX, 32'd19999);
    set_register(REG_SERVO_RESET, 32'd0);
    set_register(REG_TIMEOUT_MS, 32'd0);
    run_random(80);
    drain();

    // Full drive, inverted servo window, longest timeout and a short idle run
    set_register(REG_SPEED_LIMIT, 32'd1023);
    set_register(REG_SERVO_MIN, 32'd19999);
    set_register(REG_SERVO_MAX, 32'd0);
    set_register(REG_SERVO_RESET, 32'd19999);
    set_register(REG_TIMEOUT_MS, 32'd1023);
    run_random(80);
    send_ticks(IDLE_TICKS);
    compose_line(1'b0);
    send_line();
    drain();

    // Random window and short timeout while the receiver holds off for a while
    lo = 15'($urandom_range(19999));
    hi = 15'($urandom_range(19999));
    set_register(REG_SPEED_LIMIT, 32'($urandom_range(1023)));
    set_register(REG_SERVO_MIN, 32'(lo));
    set_register(REG_SERVO_MAX, 32'(hi));
    set_register(REG_SERVO_RESET, 32'($urandom_range(19999)));
    set_register(REG_TIMEOUT_MS, 32'($urandom_range(40)));
    hold_request = 1'b1;
    run_random(170);
    drain();

    // Let any stray word show up before the verdict
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
